// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the card access lock controller.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define CAL_ASSERT(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define CAL_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) (prop)) else $error(msg);
`else
`define CAL_ASSERT(lbl, ck, rstn, prop, msg)
`define CAL_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

// ===== rtl/cal_pkg.sv =====
// Shared types, widths, register indexes and helpers of the card access lock controller.
// No dependencies.
package cal_pkg;

    localparam int UID_W      = 56;
    localparam int LEN_W      = 4;
    localparam int OPLEN_W    = 3;
    localparam int ANGLE_W    = 8;
    localparam int STAMP_W    = 32;
    localparam int COOL_W     = 16;
    localparam int SLOT_W     = 8;
    localparam int DELTA_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_UID_BYTES = UID_W / 8;
    localparam int MAX_OPERATORS = 2;

    localparam int DEF_NUM_OPERATORS = 2;
    localparam int DEF_UID_BYTES     = 7;

    localparam logic [UID_W-1:0]   RST_OP0_UID     = 56'h0000_0029_9115_59;
    localparam logic [OPLEN_W-1:0] RST_OP0_LEN     = 3'd4;
    localparam logic [UID_W-1:0]   RST_OP1_UID     = 56'h0000_00B0_E7C0_61;
    localparam logic [OPLEN_W-1:0] RST_OP1_LEN     = 3'd4;
    localparam logic [COOL_W-1:0]  RST_COOLDOWN    = 16'd1000;
    localparam logic [ANGLE_W-1:0] RST_LOCKED_ANG  = 8'd0;
    localparam logic [ANGLE_W-1:0] RST_UNLOCK_ANG  = 8'd90;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OP0_UID         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OP0_LENGTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OP1_UID         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OP1_LENGTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKED_ANGLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOCKED_ANGLE  = 3'd6;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_UNLOCKED   = 2'd1,
        EV_LOCKED     = 2'd2,
        EV_UNKNOWN    = 2'd3
    } event_t;

    typedef struct packed {
        logic [MAX_OPERATORS-1:0][UID_W-1:0]   op_uid;
        logic [MAX_OPERATORS-1:0][OPLEN_W-1:0] op_len;
        logic [COOL_W-1:0]                     cooldown;
        logic [ANGLE_W-1:0]                    locked_angle;
        logic [ANGLE_W-1:0]                    unlocked_angle;
    } cfg_t;

    typedef struct packed {
        logic             hit;
        logic             idx;
        logic [UID_W-1:0] report_uid;
    } match_t;

    // keeps the low n bytes of a UID word
    function automatic logic [UID_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [UID_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_UID_BYTES; i++)
        begin
            if (LEN_W'(i) < n)
            begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/card_access_lock_controller_core.sv =====
// Top level of the card access lock controller: poll register, lock state and result register.
// Depends on cal_pkg, cal_cfg_regs, cal_matcher and assert_macros.svh.
//
// One result item per poll item. An accepted poll sits in the input register, is
// evaluated there against the lock state (servo step, cooldown check, operator lookup)
// and moves into the result register, which drives m_tvalid, once that register is
// empty or being read; a new poll can be taken every cycle while m_tready is
// high. The lock state is updated at the same edge the result is registered, so the
// following poll always sees it. Configuration writes are taken in any cycle.
`include "assert_macros.svh"

module card_access_lock_controller_core #(
    parameter int NUM_OPERATORS = cal_pkg::DEF_NUM_OPERATORS,
    parameter int UID_BYTES     = cal_pkg::DEF_UID_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_ms[31:0], card_uid[87:32], card_length[91:88], free_slots[99:92], zero pad
    input  logic [103:0]                   s_tdata,
    // command
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // operator_index[0], egg_delta[9:1], servo_angle[17:10], door_unlocked[18],
    // reported_uid[74:19], reported_length[78:75], zero pad
    output logic [79:0]                    m_tdata,
    // event_res
    output logic [1:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cal_pkg::UID_W-1:0]      cfg_data
);

    cal_pkg::cfg_t   cfg;
    cal_pkg::match_t match;

    // input register
    logic                              in_valid_reg;
    logic                              cmd_reg;
    logic [cal_pkg::STAMP_W-1:0]       now_reg;
    logic [cal_pkg::UID_W-1:0]         uid_reg;
    logic [cal_pkg::LEN_W-1:0]         len_reg;
    logic [cal_pkg::SLOT_W-1:0]        slots_reg;

    // lock state
    logic                              lock_open_reg, lock_open_next;
    logic [cal_pkg::STAMP_W-1:0]       stamp_reg, stamp_next;
    logic [cal_pkg::SLOT_W-1:0]        slots_unlock_reg, slots_unlock_next;
    logic [cal_pkg::ANGLE_W-1:0]       cur_angle_reg, cur_angle_next;
    logic [cal_pkg::ANGLE_W-1:0]       tgt_angle_reg, tgt_angle_next;

    // result register
    logic                              out_valid_reg;
    cal_pkg::event_t                   event_reg, event_next;
    logic                              opi_reg, opi_next;
    logic [cal_pkg::DELTA_W-1:0]       delta_reg, delta_next;   // two's complement
    logic [cal_pkg::UID_W-1:0]         ruid_reg, ruid_next;
    logic [cal_pkg::LEN_W-1:0]         rlen_reg, rlen_next;

    logic                              advance;
    logic                              in_cooldown;
    logic [cal_pkg::STAMP_W-1:0]       elapsed;

    cal_cfg_regs #(
        .NUM_OPERATORS (NUM_OPERATORS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cal_matcher #(
        .NUM_OPERATORS (NUM_OPERATORS),
        .UID_BYTES     (UID_BYTES)
    ) u_match (
        .cfg         (cfg),
        .card_uid    (uid_reg),
        .card_length (len_reg),
        .match       (match)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg   <= s_tuser;
            now_reg   <= s_tdata[31:0];
            uid_reg   <= s_tdata[87:32];
            len_reg   <= s_tdata[91:88];
            slots_reg <= s_tdata[99:92];
        end
    end

    // a stamp of zero means no earlier read, so no cooldown
    assign elapsed     = now_reg - stamp_reg;
    assign in_cooldown = (stamp_reg != '0)
                         && (elapsed < {{(cal_pkg::STAMP_W-cal_pkg::COOL_W){1'b0}}, cfg.cooldown});

    always_comb
    begin
        if (cur_angle_reg < tgt_angle_reg)
        begin
            cur_angle_next = cur_angle_reg + 1'b1;
        end
        else if (cur_angle_reg > tgt_angle_reg)
        begin
            cur_angle_next = cur_angle_reg - 1'b1;
        end
        else
        begin
            cur_angle_next = cur_angle_reg;
        end

        lock_open_next    = lock_open_reg;
        stamp_next        = stamp_reg;
        slots_unlock_next = slots_unlock_reg;
        tgt_angle_next    = tgt_angle_reg;
        event_next        = cal_pkg::EV_NONE;
        opi_next          = 1'b0;
        delta_next        = '0;
        ruid_next         = '0;
        rlen_next         = '0;

        if (cmd_reg && !in_cooldown)
        begin
            stamp_next = now_reg;
            if (match.hit)
            begin
                opi_next       = match.idx;
                lock_open_next = !lock_open_reg;
                if (!lock_open_reg)
                begin
                    tgt_angle_next    = cfg.unlocked_angle;
                    slots_unlock_next = slots_reg;
                    event_next        = cal_pkg::EV_UNLOCKED;
                end
                else
                begin
                    tgt_angle_next = cfg.locked_angle;
                    delta_next     = {1'b0, slots_unlock_reg} - {1'b0, slots_reg};
                    event_next     = cal_pkg::EV_LOCKED;
                end
            end
            else
            begin
                event_next = cal_pkg::EV_UNKNOWN;
                ruid_next  = match.report_uid;
                rlen_next  = len_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_open_reg    <= 1'b0;
            stamp_reg        <= '0;
            slots_unlock_reg <= '0;
            cur_angle_reg    <= cal_pkg::RST_LOCKED_ANG;
            tgt_angle_reg    <= cal_pkg::RST_LOCKED_ANG;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                lock_open_reg    <= lock_open_next;
                stamp_reg        <= stamp_next;
                slots_unlock_reg <= slots_unlock_next;
                cur_angle_reg    <= cur_angle_next;
                tgt_angle_reg    <= tgt_angle_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg <= event_next;
            opi_reg   <= opi_next;
            delta_reg <= delta_next;
            ruid_reg  <= ruid_next;
            rlen_reg  <= rlen_next;
        end
    end

    // servo angle and door state are the state registers themselves, updated with the result
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = event_reg;
    assign m_tdata  = {1'b0, rlen_reg, ruid_reg, lock_open_reg, cur_angle_reg,
                       delta_reg, opi_reg};

    `CAL_ASSERT(a_unlock_opens, clk, rst_n,
        (out_valid_reg && (event_reg == cal_pkg::EV_UNLOCKED)) |-> lock_open_reg,
        "unlock event with door reported locked")
    `CAL_ASSERT(a_delta_only_on_lock, clk, rst_n,
        (out_valid_reg && (event_reg != cal_pkg::EV_LOCKED)) |-> (delta_reg == '0),
        "egg delta set outside a lock event")
    `CAL_ASSERT(a_report_only_unknown, clk, rst_n,
        (out_valid_reg && (event_reg != cal_pkg::EV_UNKNOWN))
            |-> ((rlen_reg == '0) && (ruid_reg == '0)),
        "card report outside an unregistered card event")
    `CAL_ASSERT(a_servo_one_step, clk, rst_n,
        advance |=> ((cur_angle_reg == $past(cur_angle_reg))
                     || (cur_angle_reg == $past(cur_angle_reg) + 8'd1)
                     || (cur_angle_reg == $past(cur_angle_reg) - 8'd1)),
        "servo moved more than one degree in a poll")
    `CAL_ASSERT(a_state_holds_when_idle, clk, rst_n,
        !advance |=> ($stable(cur_angle_reg) && $stable(lock_open_reg) && $stable(stamp_reg)),
        "lock state changed without a poll")

endmodule

// ===== rtl/cal_cfg_regs.sv =====
// Configuration register file of the card access lock controller.
// Depends on cal_pkg.
module cal_cfg_regs #(
    parameter int NUM_OPERATORS = cal_pkg::DEF_NUM_OPERATORS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cal_pkg::UID_W-1:0]      cfg_data,
    output cal_pkg::cfg_t                  cfg
);

    cal_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_uid[0]      <= cal_pkg::RST_OP0_UID;
            cfg_reg.op_len[0]      <= cal_pkg::RST_OP0_LEN;
            cfg_reg.op_uid[1]      <= cal_pkg::RST_OP1_UID;
            // an absent second entry is held unused
            cfg_reg.op_len[1]      <= (NUM_OPERATORS > 1) ? cal_pkg::RST_OP1_LEN : '0;
            cfg_reg.cooldown       <= cal_pkg::RST_COOLDOWN;
            cfg_reg.locked_angle   <= cal_pkg::RST_LOCKED_ANG;
            cfg_reg.unlocked_angle <= cal_pkg::RST_UNLOCK_ANG;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cal_pkg::REG_OP0_UID:        cfg_reg.op_uid[0] <= cfg_data;
                cal_pkg::REG_OP0_LENGTH:     cfg_reg.op_len[0] <= cfg_data[cal_pkg::OPLEN_W-1:0];
                cal_pkg::REG_OP1_UID:
                begin
                    if (NUM_OPERATORS > 1)
                    begin
                        cfg_reg.op_uid[1] <= cfg_data;
                    end
                end
                cal_pkg::REG_OP1_LENGTH:
                begin
                    if (NUM_OPERATORS > 1)
                    begin
                        cfg_reg.op_len[1] <= cfg_data[cal_pkg::OPLEN_W-1:0];
                    end
                end
                cal_pkg::REG_COOLDOWN_MS:    cfg_reg.cooldown <= cfg_data[cal_pkg::COOL_W-1:0];
                cal_pkg::REG_LOCKED_ANGLE:   cfg_reg.locked_angle <= cfg_data[cal_pkg::ANGLE_W-1:0];
                cal_pkg::REG_UNLOCKED_ANGLE: cfg_reg.unlocked_angle <= cfg_data[cal_pkg::ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/cal_matcher.sv =====
// Operator table lookup: compares a card UID with every entry in parallel.
// Depends on cal_pkg.
module cal_matcher #(
    parameter int NUM_OPERATORS = cal_pkg::DEF_NUM_OPERATORS,
    parameter int UID_BYTES     = cal_pkg::DEF_UID_BYTES
) (
    input  cal_pkg::cfg_t                  cfg,
    input  logic [cal_pkg::UID_W-1:0]      card_uid,
    input  logic [cal_pkg::LEN_W-1:0]      card_length,
    output cal_pkg::match_t                match
);

    localparam logic [cal_pkg::LEN_W-1:0] MaxLen = cal_pkg::LEN_W'(UID_BYTES);

    always_comb
    begin
        logic                          len_ok;
        logic [cal_pkg::UID_W-1:0]     mask;
        logic [cal_pkg::LEN_W-1:0]     rep_len;
        len_ok  = (card_length != '0) && (card_length <= MaxLen);
        mask    = cal_pkg::byte_mask(card_length);
        rep_len = (card_length > MaxLen) ? MaxLen : card_length;
        match.hit = 1'b0;
        match.idx = 1'b0;
        match.report_uid = card_uid & cal_pkg::byte_mask(rep_len);
        // walk downwards so that the lowest matching entry wins
        for (int i = NUM_OPERATORS - 1; i >= 0; i--)
        begin
            if (len_ok && (cfg.op_len[i] != '0)
                && ({1'b0, cfg.op_len[i]} == card_length)
                && (((card_uid ^ cfg.op_uid[i]) & mask) == '0))
            begin
                match.hit = 1'b1;
                match.idx = 1'(i);
            end
        end
    end

endmodule

// ===== verif/lock_sb_pkg.sv =====
// Poll and result item types plus the scoreboard for the card access lock controller bench.
// Depends on cal_pkg for widths, register indexes, reset values and the event codes.
package lock_sb_pkg;

    import cal_pkg::*;

    typedef struct packed {
        logic               cmd;
        logic [STAMP_W-1:0] now;
        logic [UID_W-1:0]   uid;
        logic [LEN_W-1:0]   len;
        logic [SLOT_W-1:0]  slots;
    } poll_t;

    typedef struct packed {
        event_t             ev;
        logic               opi;
        logic [DELTA_W-1:0] delta;
        logic [ANGLE_W-1:0] angle;
        logic               door;
        logic [UID_W-1:0]   ruid;
        logic [LEN_W-1:0]   rlen;
    } lock_result_t;

    class lock_scoreboard;
        // register copy
        logic [UID_W-1:0]   op_uid [2];
        logic [OPLEN_W-1:0] op_len [2];
        logic [COOL_W-1:0]  cooldown;
        logic [ANGLE_W-1:0] closed_angle;
        logic [ANGLE_W-1:0] open_angle;
        // lock state
        bit                 door_open;
        logic [STAMP_W-1:0] last_stamp;
        logic [SLOT_W-1:0]  slots_at_open;
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] target;

        lock_result_t       pending [$];
        int                 errors;
        int                 results_seen;

        function new();
            op_uid[0]     = RST_OP0_UID;
            op_len[0]     = RST_OP0_LEN;
            op_uid[1]     = RST_OP1_UID;
            op_len[1]     = RST_OP1_LEN;
            cooldown      = RST_COOLDOWN;
            closed_angle  = RST_LOCKED_ANG;
            open_angle    = RST_UNLOCK_ANG;
            door_open     = 1'b0;
            last_stamp    = '0;
            slots_at_open = '0;
            angle         = RST_LOCKED_ANG;
            target        = RST_LOCKED_ANG;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [UID_W-1:0] val);
            case (idx)
                REG_OP0_UID:        op_uid[0]    = val;
                REG_OP0_LENGTH:     op_len[0]    = val[OPLEN_W-1:0];
                REG_OP1_UID:        op_uid[1]    = val;
                REG_OP1_LENGTH:     op_len[1]    = val[OPLEN_W-1:0];
                REG_COOLDOWN_MS:    cooldown     = val[COOL_W-1:0];
                REG_LOCKED_ANGLE:   closed_angle = val[ANGLE_W-1:0];
                REG_UNLOCKED_ANGLE: open_angle   = val[ANGLE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [UID_W-1:0] keep_bytes(logic [UID_W-1:0] v, int unsigned n);
            logic [UID_W-1:0] m;
            m = '0;
            for (int i = 0; i < UID_W / 8; i++)
            begin
                if (i < n)
                begin
                    m[8*i +: 8] = 8'hFF;
                end
            end
            return v & m;
        endfunction

        // lowest matching entry, -1 when none
        function int find_entry(logic [UID_W-1:0] uid, logic [LEN_W-1:0] len);
            if (len == 0 || len > UID_W / 8)
            begin
                return -1;
            end
            for (int i = 0; i < 2; i++)
            begin
                if (op_len[i] != 0 && {1'b0, op_len[i]} == len
                    && keep_bytes(uid, len) == keep_bytes(op_uid[i], len))
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void note_poll(poll_t p);
            lock_result_t r;
            logic [STAMP_W-1:0] since;
            int hit;
            r = '0;
            r.ev = EV_NONE;
            if (angle < target)
            begin
                angle++;
            end
            else if (angle > target)
            begin
                angle--;
            end
            since = p.now - last_stamp;
            if (p.cmd && !(last_stamp != 0 && since < {16'b0, cooldown}))
            begin
                last_stamp = p.now;
                hit = find_entry(p.uid, p.len);
                if (hit >= 0)
                begin
                    r.opi = hit[0];
                    if (!door_open)
                    begin
                        target        = open_angle;
                        door_open     = 1'b1;
                        slots_at_open = p.slots;
                        r.ev          = EV_UNLOCKED;
                    end
                    else
                    begin
                        target    = closed_angle;
                        door_open = 1'b0;
                        r.delta   = {1'b0, slots_at_open} - {1'b0, p.slots};
                        r.ev      = EV_LOCKED;
                    end
                end
                else
                begin
                    r.ev   = EV_UNKNOWN;
                    r.ruid = keep_bytes(p.uid, (p.len < UID_W / 8) ? p.len : UID_W / 8);
                    r.rlen = p.len;
                end
            end
            r.angle = angle;
            r.door  = door_open;
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        endtask

        task check_result(lock_result_t got);
            lock_result_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                report("unexpected item", 64'(got.ev), 0);
                return;
            end
            want = pending.pop_front();
            if (got.ev !== want.ev)       report("event_res", 64'(got.ev), 64'(want.ev));
            if (got.opi !== want.opi)     report("operator_index", 64'(got.opi), 64'(want.opi));
            if (got.delta !== want.delta) report("egg_delta", 64'(got.delta), 64'(want.delta));
            if (got.angle !== want.angle) report("servo_angle", 64'(got.angle), 64'(want.angle));
            if (got.door !== want.door)   report("door_unlocked", 64'(got.door), 64'(want.door));
            if (got.ruid !== want.ruid)   report("reported_uid", 64'(got.ruid), 64'(want.ruid));
            if (got.rlen !== want.rlen)   report("reported_length", 64'(got.rlen), 64'(want.rlen));
        endtask

        task drain_check();
            if (pending.size() != 0)
            begin
                report("items never returned", 0, 64'(pending.size()));
            end
        endtask
    endclass

endpackage

// ===== verif/tb_card_access_lock_controller_core.sv =====
// Bench top for card_access_lock_controller_core: directed and random polls, register phases.
// Depends on cal_pkg, lock_sb_pkg and the controller RTL.
module tb_card_access_lock_controller_core;

    import cal_pkg::*;
    import lock_sb_pkg::*;

    localparam int HOLD_CYCLES   = 40;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_POLLS   = 245;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [103:0]         s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [79:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [UID_W-1:0]     cfg_data;

    lock_scoreboard       sb;
    logic [STAMP_W-1:0]   clock_ms;
    bit                   idle_on;
    bit                   hold_req;
    bit                   stim_done;

    card_access_lock_controller_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [UID_W-1:0] rand_uid();
        return UID_W'({$urandom(), $urandom()});
    endfunction

    function automatic poll_t mk(logic cmd, logic [STAMP_W-1:0] now, logic [UID_W-1:0] uid,
                                 logic [LEN_W-1:0] len, logic [SLOT_W-1:0] slots);
        poll_t p;
        p.cmd   = cmd;
        p.now   = now;
        p.uid   = uid;
        p.len   = len;
        p.slots = slots;
        return p;
    endfunction

    // mostly past the cooldown, some just inside or on its edge, rare jumps across the wrap
    function automatic logic [STAMP_W-1:0] step_stamp();
        logic [STAMP_W-1:0] c;
        int r;
        c = {16'b0, sb.cooldown};
        r = $urandom_range(0, 49);
        if (r == 0)
            clock_ms = $urandom();
        else if (r == 1)
            clock_ms = '0;
        else if (r < 7)
            clock_ms += $urandom_range(0, c);
        else if (r < 11)
            clock_ms += (c == 0) ? c : c - $urandom_range(0, 1);
        else
            clock_ms += c + $urandom_range(0, 2000);
        return clock_ms;
    endfunction

    function automatic poll_t random_poll();
        poll_t p;
        int r;
        int k;
        p = mk(1'b1, step_stamp(), rand_uid(), LEN_W'($urandom_range(0, 10)),
               SLOT_W'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 1);
        if (r < 30)
        begin
            p.cmd = 1'b0;
        end
        else if (r < 75)
        begin
            // registered card, bytes above its length are don't-care
            p.len = {1'b0, sb.op_len[k]};
            p.uid = sb.keep_bytes(sb.op_uid[k], p.len)
                  | (p.uid & ~sb.keep_bytes({UID_W{1'b1}}, p.len));
        end
        else if (r >= 90)
        begin
            p.len = {1'b0, sb.op_len[k]};
            p.uid = sb.op_uid[k] ^ (UID_W'(8'hFF) << (8 * $urandom_range(0, 6)));
        end
        return p;
    endfunction

    function automatic lock_result_t take_result();
        lock_result_t r;
        r.ev    = event_t'(m_tuser);
        r.opi   = m_tdata[0];
        r.delta = m_tdata[9:1];
        r.angle = m_tdata[17:10];
        r.door  = m_tdata[18];
        r.ruid  = m_tdata[74:19];
        r.rlen  = m_tdata[78:75];
        return r;
    endfunction

    task automatic send_poll(input poll_t p);
        int gap;
        if (idle_on && !hold_req && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= p.cmd;
        s_tdata  <= {4'b0, p.slots, p.len, p.uid, p.now};
        do @(posedge clk); while (!s_tready);
        sb.note_poll(p);
    endtask

    // caller drops cfg_valid after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [UID_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n, input bit with_hold, input bit quiet);
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
            begin
                idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
            end
            if (with_hold && i == n / 2)
            begin
                hold_req = 1'b1;
            end
            send_poll(random_poll());
        end
        settle();
    endtask

    task automatic directed_polls();
        logic [UID_W-1:0] op0;
        logic [UID_W-1:0] op1;
        op0 = RST_OP0_UID;
        op1 = RST_OP1_UID;
        send_poll(mk(1'b0, 32'h0, '0, 4'd0, 8'd0));
        send_poll(mk(1'b0, 32'hFFFF_FFFF, {UID_W{1'b1}}, 4'd10, 8'hFF));
        // read at time zero arms no cooldown
        send_poll(mk(1'b1, 32'd0, op0, 4'd4, 8'd200));
        send_poll(mk(1'b1, 32'd5, op1, 4'd4, 8'd10));
        send_poll(mk(1'b1, 32'd6, op0, 4'd4, 8'd0));
        send_poll(mk(1'b1, 32'd1004, op0, 4'd4, 8'd0));
        send_poll(mk(1'b1, 32'd1005, op0, 4'd4, 8'd0));
        send_poll(mk(1'b1, 32'd2005, op0, 4'd4, 8'd255));
        send_poll(mk(1'b1, 32'd3005, {UID_W{1'b1}}, 4'd10, 8'd7));
        send_poll(mk(1'b1, 32'd4005, '0, 4'd0, 8'd7));
        send_poll(mk(1'b1, 32'd5005, op0 | 56'hA5A5A5_0000_0000, 4'd4, 8'd0));
        send_poll(mk(1'b1, 32'd6005, op0, 4'd5, 8'd0));
        send_poll(mk(1'b1, 32'd7005, op0 | 56'h123456_0000_0000, 4'd8, 8'd0));
        send_poll(mk(1'b1, 32'd8005, op1, 4'd4, 8'd0));
        send_poll(mk(1'b1, 32'd9005, op1, 4'd4, 8'd255));
        send_poll(mk(1'b1, 32'd10005, op1, 4'd4, 8'd0));
        // cooldown measured across the 32-bit wrap
        send_poll(mk(1'b1, 32'hFFFF_FF00, op0, 4'd4, 8'd128));
        send_poll(mk(1'b1, 32'h0000_0100, op0, 4'd4, 8'd128));
        send_poll(mk(1'b1, 32'h0000_02E8, op0, 4'd4, 8'd100));
        send_poll(mk(1'b1, 32'd0, op1, 4'd4, 8'd50));
        send_poll(mk(1'b1, 32'd1, op1, 4'd4, 8'd60));
        send_poll(mk(1'b1, 32'd1001, op0 ^ 56'h1, 4'd4, 8'd0));
        send_poll(mk(1'b0, 32'd1002, rand_uid(), 4'd3, 8'd1));
        send_poll(mk(1'b0, 32'd1003, rand_uid(), 4'd9, 8'd2));
        send_poll(mk(1'b0, 32'd1004, rand_uid(), 4'd6, 8'd3));
        clock_ms = 32'd1004;
        settle();
    endtask

    initial
    begin
        logic [UID_W-1:0] shared_uid;
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        stim_done = 1'b0;
        clock_ms  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_polls();

        // long entry, one-byte entry, no cooldown, servo swings the other way
        write_reg(REG_OP0_UID, rand_uid());
        write_reg(REG_OP0_LENGTH, UID_W'(7));
        write_reg(REG_OP1_UID, rand_uid());
        write_reg(REG_OP1_LENGTH, UID_W'(1));
        write_reg(REG_COOLDOWN_MS, UID_W'(0));
        write_reg(REG_LOCKED_ANGLE, UID_W'(180));
        write_reg(REG_UNLOCKED_ANGLE, UID_W'(0));
        cfg_valid <= 1'b0;
        run_random(PHASE_POLLS, 1'b1, 1'b0);

        // unused entry 0, all-ones entry 1, longest cooldown, angles past 180
        write_reg(REG_OP0_LENGTH, UID_W'(0));
        write_reg(REG_OP1_UID, {UID_W{1'b1}});
        write_reg(REG_OP1_LENGTH, UID_W'(7));
        write_reg(REG_COOLDOWN_MS, UID_W'(16'hFFFF));
        write_reg(REG_LOCKED_ANGLE, UID_W'(255));
        write_reg(REG_UNLOCKED_ANGLE, UID_W'(200));
        cfg_valid <= 1'b0;
        run_random(PHASE_POLLS, 1'b0, 1'b0);

        // identical entries: entry 0 must win
        shared_uid = rand_uid();
        write_reg(REG_OP0_UID, shared_uid);
        write_reg(REG_OP0_LENGTH, UID_W'(3));
        write_reg(REG_OP1_UID, shared_uid);
        write_reg(REG_OP1_LENGTH, UID_W'(3));
        write_reg(REG_COOLDOWN_MS, UID_W'(1));
        write_reg(REG_LOCKED_ANGLE, UID_W'(0));
        write_reg(REG_UNLOCKED_ANGLE, UID_W'(180));
        cfg_valid <= 1'b0;
        run_random(PHASE_POLLS, 1'b1, 1'b0);

        write_reg(REG_OP0_UID, '0);
        write_reg(REG_OP0_LENGTH, UID_W'(2));
        write_reg(REG_OP1_UID, rand_uid());
        write_reg(REG_OP1_LENGTH, UID_W'($urandom_range(1, 7)));
        write_reg(REG_COOLDOWN_MS, UID_W'($urandom_range(0, 65535)));
        write_reg(REG_LOCKED_ANGLE, UID_W'($urandom_range(0, 180)));
        write_reg(REG_UNLOCKED_ANGLE, UID_W'($urandom_range(0, 180)));
        cfg_valid <= 1'b0;
        run_random(PHASE_POLLS, 1'b0, 1'b0);

        write_reg(REG_OP0_UID, RST_OP0_UID);
        write_reg(REG_OP0_LENGTH, UID_W'(4));
        write_reg(REG_OP1_UID, rand_uid());
        write_reg(REG_OP1_LENGTH, UID_W'(6));
        write_reg(REG_COOLDOWN_MS, UID_W'(1000));
        write_reg(REG_LOCKED_ANGLE, UID_W'(10));
        write_reg(REG_UNLOCKED_ANGLE, UID_W'(90));
        cfg_valid <= 1'b0;
        run_random(PHASE_POLLS, 1'b0, 1'b1);

        stim_done = 1'b1;
    end

    task automatic rx_cycle();
        @(posedge clk);
        if (m_tvalid && m_tready)
        begin
            sb.check_result(take_result());
        end
    endtask

    // result side: random stall bursts plus the long hold-off that backs up the input
    initial
    begin
        int n;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                begin
                    rx_cycle();
                end
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 7);
                repeat (n) rx_cycle();
            end
            else
            begin
                m_tready <= 1'b1;
                rx_cycle();
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (!stim_done && quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
        end
        else
        begin
            repeat (8) @(posedge clk);
            sb.drain_check();
            if (sb.errors == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
